// ===== rtl/crc8_framed_telemetry_receiver_unit_defines.svh =====
// Assertion macros for the telemetry receiver unit.
`ifndef CRC8_FRAMED_TELEMETRY_RECEIVER_UNIT_DEFINES_SVH
`define CRC8_FRAMED_TELEMETRY_RECEIVER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define CFTR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cftr assertion failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define CFTR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cftr assertion failed");

`endif

// ===== rtl/cftr_pkg.sv =====
// Package with types, constants and the CRC-8 function of the telemetry receiver.
package cftr_pkg;

  localparam logic [7:0]  SYNC_BYTE         = 8'h55;
  localparam logic [7:0]  CRC_POLY          = 8'h07;
  localparam logic [7:0]  CRC_MSB           = 8'h80;
  localparam logic [15:0] WDOG_LIMIT_RESET  = 16'd1000;
  localparam logic [15:0] WDOG_MAX          = 16'hFFFF;
  localparam logic        OP_BYTE           = 1'b0;
  localparam logic        OP_TICK           = 1'b1;
  localparam logic [2:0]  CNT_FIRST_DATA    = 3'd1;
  localparam logic [2:0]  CNT_LAST_DATA     = 3'd4;
  localparam logic [2:0]  CNT_CRC_BYTE      = 3'd5;

  // One result request as it leaves the block.
  typedef struct packed {
    logic       frame_good;
    logic       frame_crc_error;
    logic [9:0] adc_value;
    logic [7:0] endstop_bits;
    logic [7:0] device_status;
    logic       link_ok;
  } result_t;

  // Byte-wide CRC-8 update, MSB first, no reflection.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 8'h00) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/crc8_framed_telemetry_receiver_unit.sv =====
// A result is registered in the output register, or in the skid stage while that is held.
// Throughput: one byte or tick per cycle unless stalled; state and CRC update in one pass.
// A two-entry output buffer keeps input flowing while one result waits; stall rises only
// when both entries hold results. Reset (synchronous, active low) returns to hunting,
// clears held readings and watchdog count, and sets the limit to 1000 ms.
`include "crc8_framed_telemetry_receiver_unit_defines.svh"

module crc8_framed_telemetry_receiver_unit
  import cftr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_frame_good,
  output logic        out_frame_crc_error,
  output logic [9:0]  out_adc_value,
  output logic [7:0]  out_endstop_bits,
  output logic [7:0]  out_device_status,
  output logic        out_link_ok,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_wdata
);

  logic        in_frame_r, in_frame_nxt;
  logic [2:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  frame_store_r [4];
  logic        store_we;
  logic [1:0]  store_idx;
  logic [9:0]  held_adc_r, held_adc_nxt;
  logic [7:0]  held_endstops_r, held_endstops_nxt;
  logic [7:0]  held_status_r, held_status_nxt;
  logic [15:0] ms_count_r, ms_count_nxt;
  logic [15:0] wdog_limit_r;
  logic        accept;
  logic        good;
  logic        bad;
  logic        buf_full;
  result_t     res;
  result_t     res_out;

  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign store_idx = 2'(byte_count_r - CNT_FIRST_DATA);

  // Frame tracking, CRC and watchdog update for one request.
  always_comb begin
    in_frame_nxt      = in_frame_r;
    byte_count_nxt    = byte_count_r;
    crc_nxt           = crc_r;
    held_adc_nxt      = held_adc_r;
    held_endstops_nxt = held_endstops_r;
    held_status_nxt   = held_status_r;
    ms_count_nxt      = ms_count_r;
    store_we          = 1'b0;
    good              = 1'b0;
    bad               = 1'b0;
    if (in_operation == OP_TICK) begin
      if (ms_count_r != WDOG_MAX) begin
        ms_count_nxt = ms_count_r + 16'd1;
      end
    end else if (!in_frame_r) begin
      if (in_rx_byte == SYNC_BYTE) begin
        in_frame_nxt   = 1'b1;
        byte_count_nxt = CNT_FIRST_DATA;
        crc_nxt        = crc8_update(8'h00, in_rx_byte);
      end
    end else if (byte_count_r >= CNT_FIRST_DATA && byte_count_r <= CNT_LAST_DATA) begin
      store_we       = 1'b1;
      crc_nxt        = crc8_update(crc_r, in_rx_byte);
      byte_count_nxt = byte_count_r + 3'd1;
    end else begin
      // CRC byte closes the frame.
      in_frame_nxt   = 1'b0;
      byte_count_nxt = 3'd0;
      crc_nxt        = 8'h00;
      if (in_rx_byte == crc_r) begin
        good              = 1'b1;
        held_adc_nxt      = {frame_store_r[0], frame_store_r[1][7:6]};
        held_endstops_nxt = frame_store_r[2];
        held_status_nxt   = frame_store_r[3];
        ms_count_nxt      = 16'd0;
      end else begin
        bad = 1'b1;
      end
    end
  end

  // Result request built from the updated state.
  always_comb begin
    res.frame_good      = good;
    res.frame_crc_error = bad;
    res.adc_value       = held_adc_nxt;
    res.endstop_bits    = held_endstops_nxt;
    res.device_status   = held_status_nxt;
    res.link_ok         = ms_count_nxt < wdog_limit_r;
  end

  // Control and held state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r      <= 1'b0;
      byte_count_r    <= 3'd0;
      crc_r           <= 8'h00;
      held_adc_r      <= 10'd0;
      held_endstops_r <= 8'h00;
      held_status_r   <= 8'h00;
      ms_count_r      <= 16'd0;
      wdog_limit_r    <= WDOG_LIMIT_RESET;
    end else begin
      if (accept) begin
        in_frame_r      <= in_frame_nxt;
        byte_count_r    <= byte_count_nxt;
        crc_r           <= crc_nxt;
        held_adc_r      <= held_adc_nxt;
        held_endstops_r <= held_endstops_nxt;
        held_status_r   <= held_status_nxt;
        ms_count_r      <= ms_count_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        wdog_limit_r <= cfg_wdata;
      end
    end
  end

  // Frame data bytes, written before they are read.
  always_ff @(posedge clk) begin
    if (accept && store_we) begin
      frame_store_r[store_idx] <= in_rx_byte;
    end
  end

  cftr_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_data  (res),
    .full       (buf_full),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (res_out)
  );

  assign in_stall            = buf_full;
  assign out_frame_good      = res_out.frame_good;
  assign out_frame_crc_error = res_out.frame_crc_error;
  assign out_adc_value       = res_out.adc_value;
  assign out_endstop_bits    = res_out.endstop_bits;
  assign out_device_status   = res_out.device_status;
  assign out_link_ok         = res_out.link_ok;

  // Hunting means no byte count; inside a frame the count stays within the frame.
  `CFTR_ASSERT_NOW(a_hunt_count_zero, !in_frame_r, byte_count_r == 3'd0)
  `CFTR_ASSERT_NOW(a_frame_count_range, in_frame_r,
                   byte_count_r >= CNT_FIRST_DATA && byte_count_r <= CNT_CRC_BYTE)
  // A frame cannot pass and fail at once.
  `CFTR_ASSERT_NOW(a_good_bad_exclusive, accept, !(good && bad))
  // A good frame clears the watchdog count and returns to hunting.
  `CFTR_ASSERT_NEXT(a_good_clears_wdog, accept && good, ms_count_r == 16'd0 && !in_frame_r)

endmodule

// ===== rtl/cftr_out_buf.sv =====
// Two-entry result register with skid stage for the telemetry receiver.
module cftr_out_buf
  import cftr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r, out_data_nxt;
  result_t skid_data_r, skid_data_nxt;
  logic    push;
  logic    pop;

  assign push = push_valid && !skid_valid_r;
  assign pop  = out_valid_r && !out_stall;

  // Steer a new request to the output register or, when that is held, to the skid stage.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_nxt  = push_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
